FILE: sv/pnp_pkg.sv
`default_nettype none
package pnp_pkg;

  localparam int CoordBits = 16;
  localparam int MaxVertices = 65536;
  localparam int CountBits = 17;
  localparam int IndexBits = 16;
  localparam int DistBits = 49;
  localparam int PointBits = 24;
  localparam int DiffBits = CoordBits + 1;
  localparam int NormBits = 2 * DiffBits + 1;
  localparam int DotBits = 2 * DiffBits + 2;
  localparam int TBits = 17;
  localparam int QuotBits = 16;

  localparam logic [CoordBits-1:0] RegQueryX = 16'd0;
  localparam logic [CoordBits-1:0] RegQueryY = 16'd1;

  typedef enum logic [1:0] {
    KIND_FIRST,
    KIND_SEGMENT,
    KIND_SKIP
  } kind_t;

  typedef struct packed {
    kind_t                        kind;
    logic                         last;
    logic                         first_seg;
    logic        [IndexBits-1:0]  index;
    logic signed [CoordBits-1:0]  ax;
    logic signed [CoordBits-1:0]  ay;
    logic signed [CoordBits-1:0]  bx;
    logic signed [CoordBits-1:0]  by;
    logic signed [CoordBits-1:0]  qx;
    logic signed [CoordBits-1:0]  qy;
  } job_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_MUL,
    ST_SUM,
    ST_DIV,
    ST_SCALE,
    ST_ROUND,
    ST_SQ,
    ST_DIST,
    ST_EMIT
  } state_t;

endpackage
`default_nettype wire

FILE: sv/pnp_vertex_if.sv
`default_nettype none
interface pnp_vertex_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] vertex_x;
  logic signed [15:0] vertex_y;
  logic               last_vertex;
  modport source (output valid, vertex_x, vertex_y, last_vertex, input ready);
  modport sink (input valid, vertex_x, vertex_y, last_vertex, output ready);
endinterface
`default_nettype wire

FILE: sv/pnp_result_if.sv
`default_nettype none
interface pnp_result_if;
  logic               valid;
  logic               ready;
  logic        [48:0] distance_sq;
  logic signed [23:0] closest_x;
  logic signed [23:0] closest_y;
  logic        [15:0] segment_start;
  logic        [15:0] segment_end;
  modport source (output valid, distance_sq, closest_x, closest_y, segment_start,
                  segment_end, input ready);
  modport sink (input valid, distance_sq, closest_x, closest_y, segment_start,
                segment_end, output ready);
endinterface
`default_nettype wire

FILE: sv/pnp_config_if.sv
`default_nettype none
interface pnp_config_if;
  logic        valid;
  logic        ready;
  logic [15:0] index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: sv/pnp_front.sv
`default_nettype none
module pnp_front
  import pnp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  pnp_vertex_if.sink vin,
  pnp_config_if.sink cfg,
  output job_t      job,
  output logic      job_valid,
  input  wire logic job_ready
);

  logic signed [CoordBits-1:0] query_x;
  logic signed [CoordBits-1:0] query_y;
  logic signed [CoordBits-1:0] prev_x;
  logic signed [CoordBits-1:0] prev_y;
  logic        [CountBits-1:0] vertex_count;
  logic                        take;

  assign vin.ready = job_ready;
  assign cfg.ready = 1'b1;
  assign job_valid = vin.valid;
  assign take = vin.valid && job_ready;

  always_comb begin
    job.last = vin.last_vertex;
    job.first_seg = (vertex_count == CountBits'(1));
    job.index = IndexBits'(vertex_count - CountBits'(1));
    job.ax = prev_x;
    job.ay = prev_y;
    job.bx = vin.vertex_x;
    job.by = vin.vertex_y;
    job.qx = query_x;
    job.qy = query_y;
    priority if (vertex_count == '0) begin
      job.kind = KIND_FIRST;
    end else if (vertex_count < CountBits'(MaxVertices)) begin
      job.kind = KIND_SEGMENT;
    end else begin
      job.kind = KIND_SKIP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      query_x <= '0;
      query_y <= '0;
      prev_x <= '0;
      prev_y <= '0;
      vertex_count <= '0;
    end else begin
      if (cfg.valid && cfg.index == RegQueryX) query_x <= cfg.data;
      if (cfg.valid && cfg.index == RegQueryY) query_y <= cfg.data;
      if (take) begin
        if (vin.last_vertex) begin
          prev_x <= '0;
          prev_y <= '0;
          vertex_count <= '0;
        end else if (job.kind != KIND_SKIP) begin
          prev_x <= vin.vertex_x;
          prev_y <= vin.vertex_y;
          vertex_count <= vertex_count + CountBits'(1);
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: sv/pnp_queue.sv
`default_nettype none
module pnp_queue
  import pnp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  job_t      in_job,
  input  wire logic in_valid,
  output logic      in_ready,
  output job_t      out_job,
  output logic      out_valid,
  input  wire logic out_ready
);

  job_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign in_ready = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_job = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) mem[wr_ptr] <= in_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= '0;
    end else begin
      if (in_valid && in_ready) wr_ptr <= ~wr_ptr;
      if (out_valid && out_ready) rd_ptr <= ~rd_ptr;
      unique case ({in_valid && in_ready, out_valid && out_ready})
        2'b10: count <= count + 2'd1;
        2'b01: count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: sv/pnp_back.sv
`default_nettype none
module pnp_back
  import pnp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  job_t      job,
  input  wire logic job_valid,
  output logic      job_ready,
  pnp_result_if.source rout
);

  localparam logic [DistBits-1:0] DistMax = '1;

  state_t state;
  state_t state_next;

  job_t                        cur;
  logic signed [DiffBits-1:0]  dx;
  logic signed [DiffBits-1:0]  dy;
  logic signed [DiffBits-1:0]  px;
  logic signed [DiffBits-1:0]  py;
  logic signed [2*DiffBits-1:0] m0;
  logic signed [2*DiffBits-1:0] m1;
  logic signed [2*DiffBits-1:0] m2;
  logic signed [2*DiffBits-1:0] m3;
  logic        [NormBits-1:0]  norm;
  logic        [NormBits:0]    rem;
  logic        [QuotBits-1:0]  quot;
  logic        [4:0]           step;
  logic        [TBits-1:0]     t;
  logic signed [TBits+DiffBits:0] sx;
  logic signed [TBits+DiffBits:0] sy;
  logic signed [PointBits-1:0] cx;
  logic signed [PointBits-1:0] cy;
  logic        [25:0]          ex;
  logic        [25:0]          ey;
  logic                        ovx;
  logic                        ovy;
  logic        [51:0]          qsx;
  logic        [51:0]          qsy;
  logic        [DistBits-1:0]  seg_dist;
  logic        [DistBits-1:0]  best_distance;
  logic signed [PointBits-1:0] best_x;
  logic signed [PointBits-1:0] best_y;
  logic        [IndexBits-1:0] best_index;
  logic                        single;

  logic signed [DotBits-1:0]   dot;
  logic        [NormBits:0]    rem_sh;
  logic signed [TBits+DiffBits:0] rx;
  logic signed [TBits+DiffBits:0] ry;
  logic signed [PointBits+1:0] dqx;
  logic signed [PointBits+1:0] dqy;
  logic        [52:0]          dsum;

  assign job_ready = (state == ST_IDLE);
  assign dot = DotBits'(m2) + DotBits'(m3);
  assign rem_sh = {rem[NormBits-1:0], 1'b0};
  assign rx = sx + (TBits+DiffBits+1)'(128);
  assign ry = sy + (TBits+DiffBits+1)'(128);
  assign dqx = (PointBits+2)'(cx) - (PointBits+2)'($signed({cur.qx, 8'd0}));
  assign dqy = (PointBits+2)'(cy) - (PointBits+2)'($signed({cur.qy, 8'd0}));
  assign dsum = (ovx ? 53'd0 : 53'(qsx)) + (ovy ? 53'd0 : 53'(qsy));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (job_valid) state_next = ST_DIFF;
      ST_DIFF:  state_next = ST_MUL;
      ST_MUL:   state_next = ST_SUM;
      ST_SUM:   state_next = ST_DIV;
      ST_DIV:   if (step == 5'd0) state_next = ST_SCALE;
      ST_SCALE: state_next = ST_ROUND;
      ST_ROUND: state_next = ST_SQ;
      ST_SQ:    state_next = ST_DIST;
      ST_DIST:  state_next = cur.last ? ST_EMIT : ST_IDLE;
      ST_EMIT:  if (rout.ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    rout.valid = (state == ST_EMIT);
    rout.distance_sq = best_distance;
    rout.closest_x = best_x;
    rout.closest_y = best_y;
    rout.segment_start = single ? '0 : best_index;
    rout.segment_end = single ? '0 : best_index + IndexBits'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: if (job_valid) cur <= job;
      ST_DIFF: begin
        if (cur.kind == KIND_FIRST) begin
          dx <= '0;
          dy <= '0;
          px <= '0;
          py <= '0;
          cur.ax <= cur.bx;
          cur.ay <= cur.by;
        end else begin
          dx <= DiffBits'(cur.bx) - DiffBits'(cur.ax);
          dy <= DiffBits'(cur.by) - DiffBits'(cur.ay);
          px <= DiffBits'(cur.qx) - DiffBits'(cur.ax);
          py <= DiffBits'(cur.qy) - DiffBits'(cur.ay);
        end
      end
      ST_MUL: begin
        m0 <= dx * dx;
        m1 <= dy * dy;
        m2 <= px * dx;
        m3 <= py * dy;
      end
      ST_SUM: begin
        norm <= (m0 == '0 && m1 == '0) ? NormBits'(1) : NormBits'(m0) + NormBits'(m1);
        quot <= '0;
        t <= '0;
        step <= (dot <= 0) ? 5'd0 : 5'd16;
        rem <= (dot <= 0) ? '0 : (NormBits+1)'(dot);
      end
      ST_DIV: begin
        if (step == 5'd16 && rem >= (NormBits+1)'(norm)) begin
          t <= TBits'(17'h10000);
          step <= 5'd0;
        end else if (step != 5'd0) begin
          if (rem_sh >= (NormBits+1)'(norm)) begin
            rem <= rem_sh - (NormBits+1)'(norm);
            quot <= {quot[QuotBits-2:0], 1'b1};
            if (step == 5'd1) t <= {1'b0, quot[QuotBits-2:0], 1'b1};
          end else begin
            rem <= rem_sh;
            quot <= {quot[QuotBits-2:0], 1'b0};
            if (step == 5'd1) t <= {1'b0, quot[QuotBits-2:0], 1'b0};
          end
          step <= step - 5'd1;
        end
      end
      ST_SCALE: begin
        sx <= $signed({1'b0, t}) * dx;
        sy <= $signed({1'b0, t}) * dy;
      end
      ST_ROUND: begin
        cx <= PointBits'({cur.ax, 8'd0}) + PointBits'(rx >>> 8);
        cy <= PointBits'({cur.ay, 8'd0}) + PointBits'(ry >>> 8);
      end
      ST_SQ: begin
        ex <= 26'(dqx < 0 ? -dqx : dqx);
        ey <= 26'(dqy < 0 ? -dqy : dqy);
      end
      ST_DIST: begin
      end
      ST_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    ovx = ex > 26'h2000000;
    ovy = ey > 26'h2000000;
    qsx = 52'(ex) * 52'(ex);
    qsy = 52'(ey) * 52'(ey);
    seg_dist = (ovx || ovy || dsum > 53'(DistMax)) ? DistMax : DistBits'(dsum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_distance <= DistMax;
      best_x <= '0;
      best_y <= '0;
      best_index <= '0;
      single <= 1'b0;
    end else if (state == ST_DIST) begin
      if (cur.kind == KIND_FIRST) begin
        single <= 1'b1;
        if (cur.last) begin
          best_distance <= seg_dist;
          best_x <= cx;
          best_y <= cy;
        end
      end else if (cur.kind == KIND_SEGMENT) begin
        single <= 1'b0;
        if (cur.first_seg || seg_dist < best_distance) begin
          best_distance <= seg_dist;
          best_x <= cx;
          best_y <= cy;
          best_index <= cur.index;
        end
      end
    end else if (state == ST_EMIT && rout.ready) begin
      best_distance <= DistMax;
      best_x <= '0;
      best_y <= '0;
      best_index <= '0;
      single <= 1'b0;
    end
  end

endmodule
`default_nettype wire

FILE: sv/polyline_nearest_point.sv
// Nearest point on a streamed polyline to the query point (query_x, query_y).
// The back end handles one vertex at a time: it accepts the job, forms the
// differences, products and sums, runs the 16-step restoring divider for the
// projection, then scales, rounds and computes the distance. A projection
// clamped to 0 or 1 skips the divider steps. On a last vertex the back end then
// offers the result, which is held until taken. The front end and a two-entry
// queue take the next vertices meanwhile.
`default_nettype none
module polyline_nearest_point
  import pnp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  pnp_vertex_if.sink    vin,
  pnp_config_if.sink    cfg,
  pnp_result_if.source  rout
);

  job_t f_job;
  logic f_valid;
  logic f_ready;
  job_t b_job;
  logic b_valid;
  logic b_ready;

  pnp_front u_front (
    .clk, .rst, .vin, .cfg,
    .job(f_job), .job_valid(f_valid), .job_ready(f_ready)
  );

  pnp_queue u_queue (
    .clk, .rst,
    .in_job(f_job), .in_valid(f_valid), .in_ready(f_ready),
    .out_job(b_job), .out_valid(b_valid), .out_ready(b_ready)
  );

  pnp_back u_back (
    .clk, .rst,
    .job(b_job), .job_valid(b_valid), .job_ready(b_ready), .rout
  );

`ifndef NO_ASSERTIONS
  a_end: assert property (@(posedge clk) disable iff (rst)
    rout.valid |-> rout.segment_end == rout.segment_start + 16'd1 ||
      (rout.segment_end == 16'd0 && rout.segment_start == 16'd0) ||
      rout.segment_start == 16'hffff)
    else $error("segment indices inconsistent");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rout.valid && !rout.ready |=> rout.valid && $stable(rout.distance_sq))
    else $error("result changed while stalled");
`endif

endmodule
`default_nettype wire

FILE: sim/polyline_nearest_point_test.sv
`timescale 1ns / 1ps
`default_nettype none
module polyline_nearest_point_test;
  import pnp_pkg::*;

  localparam longint DistMax = (64'd1 << 49) - 1;
  localparam int DrainCycles = 80;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               last;
  } vertex_t;

  typedef struct {
    logic        [48:0] dsq;
    logic signed [23:0] cx;
    logic signed [23:0] cy;
    logic        [15:0] seg_start;
    logic        [15:0] seg_end;
  } nearest_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pnp_vertex_if vin();
  pnp_config_if cfg();
  pnp_result_if rout();

  polyline_nearest_point u_dut (
    .clk  (clk),
    .rst  (rst),
    .vin  (vin.sink),
    .cfg  (cfg.sink),
    .rout (rout.source)
  );

  always #5 clk = ~clk;

  vertex_t  pending_vertices[$];
  nearest_t expected_nearest[$];
  vertex_t  cur_vertex;
  int       mismatches = 0;
  int       results_seen = 0;
  int       paths_sent = 0;
  int       vertices_sent = 0;
  bit       hold_sender = 1'b0;

  // Predictor state
  longint q_x = 0, q_y = 0;
  longint pv_x = 0, pv_y = 0;
  int     pv_count = 0;
  longint best_dist = DistMax, best_cx = 0, best_cy = 0;
  int     best_idx = 0;

  function automatic longint square_sat(longint d);
    longint a;
    a = (d < 0) ? -d : d;
    if (a > (64'd1 << 25)) return DistMax + 1;
    return a * a;
  endfunction

  function automatic longint dist_to_query(longint cx, longint cy);
    longint s;
    s = square_sat(cx - q_x * 256) + square_sat(cy - q_y * 256);
    return (s > DistMax) ? DistMax : s;
  endfunction

  function automatic longint project_t(longint dot, longint norm);
    longint r, q;
    if (dot <= 0) return 0;
    if (dot >= norm) return 65536;
    r = dot;
    q = 0;
    for (int i = 0; i < 16; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= norm) begin
        r = r - norm;
        q = q | 1;
      end
    end
    return q;
  endfunction

  function automatic void clear_path();
    pv_x = 0;
    pv_y = 0;
    pv_count = 0;
    best_dist = DistMax;
    best_cx = 0;
    best_cy = 0;
    best_idx = 0;
  endfunction

  function automatic void predict_vertex(vertex_t v);
    longint x, y, dx, dy, norm, dot, t, cx, cy, d;
    nearest_t res;
    x = v.x;
    y = v.y;
    if (pv_count == 0) begin
      pv_x = x;
      pv_y = y;
      pv_count = 1;
    end else if (pv_count < MaxVertices) begin
      dx = x - pv_x;
      dy = y - pv_y;
      norm = dx * dx + dy * dy;
      dot = (q_x - pv_x) * dx + (q_y - pv_y) * dy;
      if (norm == 0) norm = 1;
      t = project_t(dot, norm);
      cx = pv_x * 256 + ((t * dx + 128) >>> 8);
      cy = pv_y * 256 + ((t * dy + 128) >>> 8);
      d = dist_to_query(cx, cy);
      if (pv_count == 1 || d < best_dist) begin
        best_dist = d;
        best_cx = cx;
        best_cy = cy;
        best_idx = pv_count - 1;
      end
      pv_x = x;
      pv_y = y;
      pv_count++;
    end
    if (!v.last) return;
    if (pv_count == 1) begin
      res.dsq = 49'(dist_to_query(pv_x * 256, pv_y * 256));
      res.cx = 24'(pv_x * 256);
      res.cy = 24'(pv_y * 256);
      res.seg_start = '0;
      res.seg_end = '0;
    end else begin
      res.dsq = 49'(best_dist);
      res.cx = 24'(best_cx);
      res.cy = 24'(best_cy);
      res.seg_start = 16'(best_idx);
      res.seg_end = 16'(best_idx + 1);
    end
    expected_nearest = {expected_nearest, res};
    clear_path();
  endfunction

  // Sender: bursts and gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      vin.valid <= 1'b0;
      vin.vertex_x <= '0;
      vin.vertex_y <= '0;
      vin.last_vertex <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (vin.valid && vin.ready) begin
        predict_vertex(cur_vertex);
        vertices_sent++;
        if (cur_vertex.last) paths_sent++;
      end
      if (!vin.valid || vin.ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          vin.valid <= 1'b0;
        end else if (!hold_sender && pending_vertices.size() > 0) begin
          cur_vertex = pending_vertices.pop_front();
          vin.valid <= 1'b1;
          vin.vertex_x <= cur_vertex.x;
          vin.vertex_y <= cur_vertex.y;
          vin.last_vertex <= cur_vertex.last;
          if (burst_left <= 0) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          vin.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: switches at random among four stall patterns
  int stall_mode = 0;
  int cycle_cnt = 0;

  always @(posedge clk) begin
    if (rst) begin
      rout.ready <= 1'b0;
    end else begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt % 64 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0: rout.ready <= 1'b1;
        1: rout.ready <= 1'($urandom_range(0, 1));
        2: rout.ready <= ($urandom_range(0, 7) == 0);
        default: rout.ready <= (cycle_cnt % 16) < 4;
      endcase
    end
  end

  // Result checker
  always @(posedge clk) begin
    nearest_t exp_r;
    if (!rst && rout.valid && rout.ready) begin
      results_seen++;
      if (expected_nearest.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result dist=%0d", rout.distance_sq);
      end else begin
        exp_r = expected_nearest.pop_front();
        if (rout.distance_sq !== exp_r.dsq || rout.closest_x !== exp_r.cx ||
            rout.closest_y !== exp_r.cy || rout.segment_start !== exp_r.seg_start ||
            rout.segment_end !== exp_r.seg_end) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp d=%0d x=%0d y=%0d s=%0d e=%0d got d=%0d x=%0d y=%0d s=%0d e=%0d",
                     exp_r.dsq, exp_r.cx, exp_r.cy, exp_r.seg_start, exp_r.seg_end,
                     rout.distance_sq, rout.closest_x, rout.closest_y,
                     rout.segment_start, rout.segment_end);
        end
      end
    end
  end

  task automatic add_vertex(int x, int y, bit last);
    vertex_t v;
    v.x = 16'(x);
    v.y = 16'(y);
    v.last = last;
    pending_vertices = {pending_vertices, v};
  endtask

  function automatic int rand_coord(int center);
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 1) ? 32767 : -32768;
      1: return $signed(16'($urandom));
      2: return $signed(16'(center + $urandom_range(0, 64) - 32));
      default: return $signed(16'(center + $urandom_range(0, 2000) - 1000));
    endcase
  endfunction

  task automatic add_path(int n, bit closed);
    int x, y;
    for (int i = 0; i < n; i++) begin
      if (i > 0 && $urandom_range(0, 9) == 0) begin
        x = pending_vertices[$].x;
        y = pending_vertices[$].y;
      end else begin
        x = rand_coord(int'(q_x));
        y = rand_coord(int'(q_y));
      end
      add_vertex(x, y, closed && (i == n - 1));
    end
  endtask

  task automatic drain();
    hold_sender = 1'b0;
    while (pending_vertices.size() > 0 || vin.valid || expected_nearest.size() > 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_query(logic [15:0] idx, logic [15:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= data;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    if (idx == RegQueryX) q_x = $signed(data);
    else q_y = $signed(data);
  endtask

  initial begin
    int qx, qy;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_query(RegQueryX, 16'd100);
    write_query(RegQueryY, 16'd50);
    // single vertex, both extremes
    add_vertex(32767, 32767, 1);
    add_vertex(-32768, -32768, 1);
    // zero-length segment, then clamp below and above
    add_vertex(10, 10, 0);
    add_vertex(10, 10, 1);
    add_vertex(200, 0, 0);
    add_vertex(300, 0, 1);
    add_vertex(-300, 0, 0);
    add_vertex(-200, 0, 1);
    // tie: symmetric segments
    add_vertex(0, 0, 0);
    add_vertex(200, 0, 0);
    add_vertex(0, 0, 1);
    // interior projection with rounding
    add_vertex(0, 0, 0);
    add_vertex(7, 3, 0);
    add_vertex(301, 117, 1);
    drain();

    // largest distances, query in the lowest corner
    write_query(RegQueryX, 16'h8000);
    write_query(RegQueryY, 16'h8000);
    add_vertex(32767, 32767, 1);
    add_vertex(32767, 32767, 0);
    add_vertex(32767, -32768, 1);
    add_vertex(-32768, -32768, 0);
    add_vertex(32767, 32767, 0);
    drain();
    // query change mid path
    write_query(RegQueryX, 16'h7fff);
    write_query(RegQueryY, 16'h7fff);
    add_vertex(0, 0, 1);
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin qx = 0; qy = 0; end
        1: begin qx = 32767; qy = -32768; end
        default: begin qx = $signed(16'($urandom)); qy = $signed(16'($urandom)); end
      endcase
      write_query(RegQueryX, 16'(qx));
      write_query(RegQueryY, 16'(qy));
      while (pending_vertices.size() < 130)
        add_path(($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 12), 1);
      if (phase % 2 == 1) add_path(3, 0);
      drain();
    end

    $display("covered %0d vertices in %0d paths, %0d results checked",
             vertices_sent, paths_sent, results_seen);
    if (mismatches == 0) begin
      $display("polyline_nearest_point_test OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("polyline_nearest_point_test NOT OK");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout");
    $display("polyline_nearest_point_test NOT OK");
    $finish;
  end

endmodule
`default_nettype wire
